// File: rtl/stroked_polyline_bounding_box_core_macros.svh
// Assertion macros shared by the stroked polyline bounding box RTL
`ifndef STROKED_POLYLINE_BOUNDING_BOX_CORE_MACROS_SVH
`define STROKED_POLYLINE_BOUNDING_BOX_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define SPBB_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spbb same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define SPBB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spbb next-cycle check failed");

`endif

// File: rtl/spbb_pkg.sv
// Shared constants and types of the stroked polyline bounding box core
`default_nettype none

package spbb_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 14;

    // unit vector component, signed Q2.FRAC_BITS
    localparam int CW     = FRAC_BITS + 2;
    // dot and cross products
    localparam int XW     = 2 * CW + 1;
    localparam int NORM_W = (COORD_BITS + 1 > 31) ? COORD_BITS + 1 : 31;
    localparam int NUM_W  = (FRAC_BITS + 33 > 2 * FRAC_BITS + 10) ?
                            FRAC_BITS + 33 : 2 * FRAC_BITS + 10;
    localparam int DEN_W  = (2 * FRAC_BITS + 5 > 34) ? 2 * FRAC_BITS + 5 : 34;
    localparam int REM_W  = DEN_W + 2;
    localparam int OP_W   = 64;
    localparam int SQRT_STEPS = 32;
    localparam int IT_CNT_W   = $clog2(NUM_W);
    localparam int BOX_W  = ((COORD_BITS > 2 * FRAC_BITS + 9) ?
                            COORD_BITS : 2 * FRAC_BITS + 9) + 2;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;
    localparam int OUT_W  = 17;

    localparam int S_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((4 * OUT_W + 7) / 8) * 8;
    localparam int APB_ADDR_W = 4;

    localparam logic [1:0] REG_THICK = 2'd0;
    localparam logic [1:0] REG_MITER = 2'd1;
    localparam logic [1:0] REG_PROJ  = 2'd2;

    // cos(11 deg) in Q30
    localparam logic [63:0] COS_LIMIT_Q30 = 64'd1054014162;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } it_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/spbb_iter.sv
// Shared iterative unit: restoring square root and restoring division
`default_nettype none

module spbb_iter import spbb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  it_ctrl_t         ctrl,
    input  logic [OP_W-1:0]  opnd,     // radicand, or numerator left aligned
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] res
);

    logic                busy_reg;
    logic                done_reg;
    logic                mode_reg;
    logic [IT_CNT_W-1:0] cnt_reg;
    logic [OP_W-1:0]     op_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [NUM_W-1:0]    q_reg;
    logic [DEN_W-1:0]    den_reg;

    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] diff;
    logic             ge;

    // one digit per cycle through a single compare and subtract
    always_comb begin
        if (mode_reg) begin
            rs    = {rem_reg[REM_W-3:0], op_reg[OP_W-1 -: 2]};
            trial = REM_W'({q_reg, 2'b01});
        end else begin
            rs    = {rem_reg[REM_W-2:0], op_reg[OP_W-1]};
            trial = REM_W'(den_reg);
        end
        ge   = (rs >= trial);
        diff = rs - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                mode_reg <= ctrl.sqrt_mode;
                op_reg   <= opnd;
                den_reg  <= den;
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= ctrl.sqrt_mode ? IT_CNT_W'(SQRT_STEPS - 1) : IT_CNT_W'(NUM_W - 1);
            end else if (busy_reg) begin
                rem_reg <= ge ? diff : rs;
                q_reg   <= {q_reg[NUM_W-2:0], ge};
                op_reg  <= mode_reg ? (op_reg << 2) : (op_reg << 1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = q_reg;

endmodule

`default_nettype wire

// File: rtl/stroked_polyline_bounding_box_core.sv
// Top level of the stroked polyline bounding box core
//
// Usage: polyline points arrive one word per point on the s_ stream, tlast
// marking the final point. Each final point yields one word on the m_ stream
// with the box left, top, width and height, saturated to 17 bits; other
// points yield nothing. Thickness, miter join and projecting cap registers
// sit on the APB port and are to be written only while no polyline is in
// flight; the block itself does not enforce this. A point that repeats the
// current vertex only updates the extents. A point that moves is normalized
// by shifts, squared in the shared multiplier and put through a 32-step
// square root and two divisions of NUM_W steps (47) in the shared
// root/divide unit; a mitered join adds the dot and cross products and two
// more divisions, a bevel join the products only. The shared unit sets the
// rate: one point is in work at a time and s_tready stays low meanwhile.
// Reset clears the configuration registers to zero and empties the output
// word. If the receiver stalls, the result word holds and the points of the
// next polyline still go through; its final point waits with s_tready low
// until the word is taken.
`default_nettype none

module stroked_polyline_bounding_box_core import spbb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // point_x, point_y
    input  logic                  s_tlast,   // last_point
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // box_left, box_top, box_width, box_height
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    `include "stroked_polyline_bounding_box_core_macros.svh"

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_POINT = 5'd1;
    localparam logic [4:0] ST_NORM  = 5'd2;
    localparam logic [4:0] ST_SQX   = 5'd3;
    localparam logic [4:0] ST_SQY   = 5'd4;
    localparam logic [4:0] ST_SQGO  = 5'd5;
    localparam logic [4:0] ST_SQW   = 5'd6;
    localparam logic [4:0] ST_DXGO  = 5'd7;
    localparam logic [4:0] ST_DXW   = 5'd8;
    localparam logic [4:0] ST_DYGO  = 5'd9;
    localparam logic [4:0] ST_DYW   = 5'd10;
    localparam logic [4:0] ST_DIR   = 5'd11;
    localparam logic [4:0] ST_JD1   = 5'd12;
    localparam logic [4:0] ST_JD2   = 5'd13;
    localparam logic [4:0] ST_JC1   = 5'd14;
    localparam logic [4:0] ST_JC2   = 5'd15;
    localparam logic [4:0] ST_JDEC  = 5'd16;
    localparam logic [4:0] ST_JXM   = 5'd17;
    localparam logic [4:0] ST_JXGO  = 5'd18;
    localparam logic [4:0] ST_JXW   = 5'd19;
    localparam logic [4:0] ST_JYM   = 5'd20;
    localparam logic [4:0] ST_JYGO  = 5'd21;
    localparam logic [4:0] ST_JYW   = 5'd22;
    localparam logic [4:0] ST_JGROW = 5'd23;
    localparam logic [4:0] ST_FIN   = 5'd24;
    localparam logic [4:0] ST_CAP1  = 5'd25;
    localparam logic [4:0] ST_CAP2  = 5'd26;
    localparam logic [4:0] ST_OUT   = 5'd27;

    // configuration
    logic [7:0] thick_reg;
    logic       miter_reg;
    logic       proj_reg;

    logic [4:0] state_reg, state_next;
    logic signed [COORD_BITS-1:0] px_reg, px_next, py_reg, py_next;
    logic                         last_reg, last_next;
    logic signed [COORD_BITS-1:0] fx_reg, fx_next, fy_reg, fy_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [CW-1:0]         fdx_reg, fdx_next, fdy_reg, fdy_next;
    logic signed [CW-1:0]         idx_reg, idx_next, idy_reg, idy_next;
    logic signed [CW-1:0]         dux_reg, dux_next, duy_reg, duy_next;
    logic signed [CW-1:0]         ax_reg, ax_next, ay_reg, ay_next;
    logic signed [CW-1:0]         bx_reg, bx_next, by_reg, by_next;
    logic signed [COORD_BITS-1:0] jx_reg, jx_next, jy_reg, jy_next;
    logic signed [BOX_W-1:0]      jl_reg, jl_next, jt_reg, jt_next;
    logic signed [BOX_W-1:0]      jr_reg, jr_next, jb_reg, jb_next;
    logic signed [COORD_BITS-1:0] pl_reg, pl_next, pt_reg, pt_next;
    logic signed [COORD_BITS-1:0] pr_reg, pr_next, pb_reg, pb_next;
    logic [1:0]                   cnt_reg, cnt_next;
    logic                         dvalid_reg, dvalid_next;
    logic [NORM_W-1:0]            mx_reg, mx_next, my_reg, my_next;
    logic                         sgnx_reg, sgnx_next, sgny_reg, sgny_next;
    logic [31:0]                  mag_reg, mag_next;
    logic signed [XW-1:0]         dot_reg, dot_next, cross_reg, cross_next;
    logic signed [PROD_W-1:0]     acc_reg, acc_next;
    logic signed [BOX_W-1:0]      ox_reg, ox_next, oy_reg, oy_next;
    logic                         close_reg, close_next;
    logic                         plain_reg, plain_next;
    logic                         mval_reg, mval_next;
    logic [4*OUT_W-1:0]           mdata_reg, mdata_next;

    // shared unit
    it_ctrl_t         it_ctrl;
    logic [OP_W-1:0]  it_opnd;
    logic [DEN_W-1:0] it_den;
    logic             it_done;
    logic [NUM_W-1:0] it_res;

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    // box grow port
    logic                    g_en;
    logic signed [BOX_W-1:0] gl, gt, gr, gb;

    logic signed [COORD_BITS:0] dx_w, dy_w;
    logic [COORD_BITS:0]        adx, ady;
    logic [NORM_W-1:0]          m_max;
    logic [NORM_W:0]            m_ext;
    logic                       m_big;
    logic [NUM_W-1:0]           num_dir, num_join;
    logic [DEN_W-1:0]           den_dir, den_join;
    logic [XW-1:0]              cabs, adot;
    logic [63:0]                adot_sh;
    logic                       bevel;
    logic signed [CW:0]         sx_w, sy_w;
    logic [CW:0]                ux, uy;
    logic signed [CW-1:0]       q_dir;
    logic signed [BOX_W-1:0]    lo_b, hi_b, cap_b, th_b;
    logic signed [BOX_W-1:0]    ol, ot, orr, ob;
    logic signed [BOX_W:0]      wid, hgt;
    logic                       cfg_wr;

    function automatic logic [OUT_W-1:0] sat_pos(input logic signed [BOX_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v < -65536) begin
            r = 17'h10000;
        end else if (v > 65535) begin
            r = 17'h0FFFF;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] sat_len(input logic signed [BOX_W:0] v);
        logic [OUT_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > 131071) begin
            r = 17'h1FFFF;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    spbb_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (it_ctrl),
        .opnd    (it_opnd),
        .den     (it_den),
        .done    (it_done),
        .res     (it_res)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thick_reg <= '0;
            miter_reg <= 1'b0;
            proj_reg  <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_THICK: thick_reg <= pwdata[7:0];
                REG_MITER: miter_reg <= pwdata[0];
                REG_PROJ:  proj_reg  <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_THICK: prdata = {24'd0, thick_reg};
            REG_MITER: prdata = {31'd0, miter_reg};
            REG_PROJ:  prdata = {31'd0, proj_reg};
            default:   prdata = '0;
        endcase
    end

    // datapath helpers
    assign prod = mul_a * mul_b;

    always_comb begin
        dx_w  = {px_reg[COORD_BITS-1], px_reg} - {cx_reg[COORD_BITS-1], cx_reg};
        dy_w  = {py_reg[COORD_BITS-1], py_reg} - {cy_reg[COORD_BITS-1], cy_reg};
        adx   = dx_w < 0 ? $unsigned(-dx_w) : $unsigned(dx_w);
        ady   = dy_w < 0 ? $unsigned(-dy_w) : $unsigned(dy_w);
        m_max = (mx_reg > my_reg) ? mx_reg : my_reg;
        m_ext = {1'b0, m_max};
        m_big = (m_ext >= (NORM_W + 1)'(64'h8000_0000));

        den_dir = DEN_W'({mag_reg, 1'b0});
        num_dir = (NUM_W'((state_reg == ST_DYGO) ? my_reg[30:0] : mx_reg[30:0])
                   << (FRAC_BITS + 1)) + NUM_W'(mag_reg);

        cabs     = cross_reg < 0 ? $unsigned(-cross_reg) : $unsigned(cross_reg);
        den_join = DEN_W'({cabs, 1'b0});
        num_join = (NUM_W'($unsigned(acc_reg)) << FRAC_BITS) + NUM_W'(den_join) - NUM_W'(1);

        adot    = dot_reg < 0 ? $unsigned(-dot_reg) : $unsigned(dot_reg);
        adot_sh = 64'(adot) << (48 - 2 * FRAC_BITS);
        bevel   = (adot_sh > (COS_LIMIT_Q30 << 18)) || (acc_reg == 0);

        sx_w = {ax_reg[CW-1], ax_reg} + {bx_reg[CW-1], bx_reg};
        sy_w = {ay_reg[CW-1], ay_reg} + {by_reg[CW-1], by_reg};
        ux   = sx_w < 0 ? $unsigned(-sx_w) : $unsigned(sx_w);
        uy   = sy_w < 0 ? $unsigned(-sy_w) : $unsigned(sy_w);

        q_dir = CW'(it_res);

        lo_b  = BOX_W'({1'b0, thick_reg[7:1]});
        hi_b  = BOX_W'(({1'b0, thick_reg} + 9'd1) >> 1);
        th_b  = lo_b;
        cap_b = proj_reg ? BOX_W'({1'b0, thick_reg}) : lo_b;

        if (plain_reg) begin
            ol  = BOX_W'(pl_reg) - th_b;
            ot  = BOX_W'(pt_reg) - th_b;
            orr = BOX_W'(pr_reg) + th_b;
            ob  = BOX_W'(pb_reg) + th_b;
        end else begin
            ol  = jl_reg;
            ot  = jt_reg;
            orr = jr_reg;
            ob  = jb_reg;
        end
        wid = (BOX_W + 1)'(orr) - (BOX_W + 1)'(ol) + 1;
        hgt = (BOX_W + 1)'(ob) - (BOX_W + 1)'(ot) + 1;
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        px_next     = px_reg;     py_next    = py_reg;     last_next  = last_reg;
        fx_next     = fx_reg;     fy_next    = fy_reg;
        cx_next     = cx_reg;     cy_next    = cy_reg;
        fdx_next    = fdx_reg;    fdy_next   = fdy_reg;
        idx_next    = idx_reg;    idy_next   = idy_reg;
        dux_next    = dux_reg;    duy_next   = duy_reg;
        ax_next     = ax_reg;     ay_next    = ay_reg;
        bx_next     = bx_reg;     by_next    = by_reg;
        jx_next     = jx_reg;     jy_next    = jy_reg;
        jl_next     = jl_reg;     jt_next    = jt_reg;
        jr_next     = jr_reg;     jb_next    = jb_reg;
        pl_next     = pl_reg;     pt_next    = pt_reg;
        pr_next     = pr_reg;     pb_next    = pb_reg;
        cnt_next    = cnt_reg;    dvalid_next = dvalid_reg;
        mx_next     = mx_reg;     my_next    = my_reg;
        sgnx_next   = sgnx_reg;   sgny_next  = sgny_reg;
        mag_next    = mag_reg;
        dot_next    = dot_reg;    cross_next = cross_reg;
        acc_next    = acc_reg;
        ox_next     = ox_reg;     oy_next    = oy_reg;
        close_next  = close_reg;  plain_next = plain_reg;
        mval_next   = mval_reg;   mdata_next = mdata_reg;
        it_ctrl     = '0;
        it_opnd     = '0;
        it_den      = '0;
        mul_a       = '0;
        mul_b       = '0;
        g_en        = 1'b0;
        gl = '0; gt = '0; gr = '0; gb = '0;

        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    px_next    = $signed(s_tdata[COORD_BITS-1:0]);
                    py_next    = $signed(s_tdata[2*COORD_BITS-1:COORD_BITS]);
                    last_next  = s_tlast;
                    state_next = ST_POINT;
                end
            end
            ST_POINT: begin
                if (cnt_reg == 2'd0) begin
                    fx_next = px_reg;  fy_next = py_reg;
                    cx_next = px_reg;  cy_next = py_reg;
                    dvalid_next = 1'b0;
                    jl_next = BOX_W'(px_reg);  jr_next = BOX_W'(px_reg);
                    jt_next = BOX_W'(py_reg);  jb_next = BOX_W'(py_reg);
                    pl_next = px_reg;  pr_next = px_reg;
                    pt_next = py_reg;  pb_next = py_reg;
                    cnt_next   = 2'd1;
                    state_next = ST_FIN;
                end else begin
                    if (cnt_reg != 2'd3) begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                    if (px_reg < pl_reg) pl_next = px_reg;
                    if (py_reg < pt_reg) pt_next = py_reg;
                    if (px_reg > pr_reg) pr_next = px_reg;
                    if (py_reg > pb_reg) pb_next = py_reg;
                    if (px_reg != cx_reg || py_reg != cy_reg) begin
                        mx_next    = NORM_W'(adx);
                        my_next    = NORM_W'(ady);
                        sgnx_next  = dx_w < 0;
                        sgny_next  = dy_w < 0;
                        state_next = ST_NORM;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_NORM: begin
                // bring the larger magnitude into [2^30, 2^31)
                if (m_big) begin
                    mx_next = mx_reg >> 1;
                    my_next = my_reg >> 1;
                end else if (!m_max[30]) begin
                    mx_next = mx_reg << 1;
                    my_next = my_reg << 1;
                end else begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX: begin
                mul_a      = $signed({1'b0, mx_reg[30:0]});
                mul_b      = $signed({1'b0, mx_reg[30:0]});
                acc_next   = prod;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                mul_a      = $signed({1'b0, my_reg[30:0]});
                mul_b      = $signed({1'b0, my_reg[30:0]});
                acc_next   = acc_reg + prod;
                state_next = ST_SQGO;
            end
            ST_SQGO: begin
                it_ctrl.start     = 1'b1;
                it_ctrl.sqrt_mode = 1'b1;
                it_opnd           = $unsigned(acc_reg);
                state_next        = ST_SQW;
            end
            ST_SQW: begin
                if (it_done) begin
                    mag_next   = it_res[31:0];
                    state_next = ST_DXGO;
                end
            end
            ST_DXGO: begin
                it_ctrl.start = 1'b1;
                it_opnd       = {num_dir, {(OP_W - NUM_W){1'b0}}};
                it_den        = den_dir;
                state_next    = ST_DXW;
            end
            ST_DXW: begin
                if (it_done) begin
                    dux_next   = sgnx_reg ? -q_dir : q_dir;
                    state_next = ST_DYGO;
                end
            end
            ST_DYGO: begin
                it_ctrl.start = 1'b1;
                it_opnd       = {num_dir, {(OP_W - NUM_W){1'b0}}};
                it_den        = den_dir;
                state_next    = ST_DYW;
            end
            ST_DYW: begin
                if (it_done) begin
                    duy_next   = sgny_reg ? -q_dir : q_dir;
                    state_next = ST_DIR;
                end
            end
            ST_DIR: begin
                idx_next = dux_reg;
                idy_next = duy_reg;
                cx_next  = px_reg;
                cy_next  = py_reg;
                if (!dvalid_reg) begin
                    fdx_next    = dux_reg;
                    fdy_next    = duy_reg;
                    dvalid_next = 1'b1;
                    state_next  = ST_FIN;
                end else begin
                    ax_next    = -idx_reg;
                    ay_next    = -idy_reg;
                    bx_next    = dux_reg;
                    by_next    = duy_reg;
                    jx_next    = cx_reg;
                    jy_next    = cy_reg;
                    close_next = 1'b0;
                    state_next = ST_JD1;
                end
            end
            ST_JD1: begin
                mul_a      = MUL_W'(ax_reg);
                mul_b      = MUL_W'(bx_reg);
                acc_next   = prod;
                state_next = ST_JD2;
            end
            ST_JD2: begin
                mul_a      = MUL_W'(ay_reg);
                mul_b      = MUL_W'(by_reg);
                acc_next   = acc_reg + prod;
                state_next = ST_JC1;
            end
            ST_JC1: begin
                dot_next   = XW'(acc_reg);
                mul_a      = MUL_W'(ax_reg);
                mul_b      = MUL_W'(by_reg);
                acc_next   = prod;
                state_next = ST_JC2;
            end
            ST_JC2: begin
                mul_a      = MUL_W'(ay_reg);
                mul_b      = MUL_W'(bx_reg);
                acc_next   = acc_reg - prod;
                state_next = ST_JDEC;
            end
            ST_JDEC: begin
                cross_next = XW'(acc_reg);
                if (bevel) begin
                    g_en = 1'b1;
                    gl   = BOX_W'(jx_reg) - lo_b;
                    gt   = BOX_W'(jy_reg) - lo_b;
                    gr   = BOX_W'(jx_reg) + hi_b;
                    gb   = BOX_W'(jy_reg) + hi_b;
                    state_next = close_reg ? ST_OUT : ST_FIN;
                end else begin
                    state_next = ST_JXM;
                end
            end
            ST_JXM: begin
                mul_a      = MUL_W'($signed({1'b0, thick_reg}));
                mul_b      = MUL_W'($signed({1'b0, ux}));
                acc_next   = prod;
                state_next = ST_JXGO;
            end
            ST_JXGO: begin
                it_ctrl.start = 1'b1;
                it_opnd       = {num_join, {(OP_W - NUM_W){1'b0}}};
                it_den        = den_join;
                state_next    = ST_JXW;
            end
            ST_JXW: begin
                if (it_done) begin
                    ox_next    = $signed(BOX_W'(it_res));
                    state_next = ST_JYM;
                end
            end
            ST_JYM: begin
                mul_a      = MUL_W'($signed({1'b0, thick_reg}));
                mul_b      = MUL_W'($signed({1'b0, uy}));
                acc_next   = prod;
                state_next = ST_JYGO;
            end
            ST_JYGO: begin
                it_ctrl.start = 1'b1;
                it_opnd       = {num_join, {(OP_W - NUM_W){1'b0}}};
                it_den        = den_join;
                state_next    = ST_JYW;
            end
            ST_JYW: begin
                if (it_done) begin
                    oy_next    = $signed(BOX_W'(it_res));
                    state_next = ST_JGROW;
                end
            end
            ST_JGROW: begin
                g_en = 1'b1;
                gl   = BOX_W'(jx_reg) - ox_reg;
                gt   = BOX_W'(jy_reg) - oy_reg;
                gr   = BOX_W'(jx_reg) + ox_reg;
                gb   = BOX_W'(jy_reg) + oy_reg;
                state_next = close_reg ? ST_OUT : ST_FIN;
            end
            ST_FIN: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (thick_reg == 8'd0 || !miter_reg || cnt_reg <= 2'd2) begin
                    plain_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    plain_next = 1'b0;
                    if (px_reg == fx_reg && py_reg == fy_reg) begin
                        // closed line: join at the first vertex
                        if (dvalid_reg) begin
                            ax_next    = -idx_reg;
                            ay_next    = -idy_reg;
                            bx_next    = fdx_reg;
                            by_next    = fdy_reg;
                            jx_next    = fx_reg;
                            jy_next    = fy_reg;
                            close_next = 1'b1;
                            state_next = ST_JD1;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end else begin
                        state_next = ST_CAP1;
                    end
                end
            end
            ST_CAP1: begin
                g_en = 1'b1;
                gl   = BOX_W'(fx_reg) - cap_b;
                gt   = BOX_W'(fy_reg) - cap_b;
                gr   = BOX_W'(fx_reg) + cap_b;
                gb   = BOX_W'(fy_reg) + cap_b;
                state_next = ST_CAP2;
            end
            ST_CAP2: begin
                g_en = 1'b1;
                gl   = BOX_W'(px_reg) - cap_b;
                gt   = BOX_W'(py_reg) - cap_b;
                gr   = BOX_W'(px_reg) + cap_b;
                gb   = BOX_W'(py_reg) + cap_b;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output word is free
                if (!mval_reg || m_tready) begin
                    mdata_next  = {sat_len(hgt), sat_len(wid), sat_pos(ot), sat_pos(ol)};
                    mval_next   = 1'b1;
                    cnt_next    = 2'd0;
                    dvalid_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (g_en) begin
            if (gl < jl_reg) jl_next = gl;
            if (gt < jt_reg) jt_next = gt;
            if (gr > jr_reg) jr_next = gr;
            if (gb > jb_reg) jb_next = gb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 2'd0;
            dvalid_reg <= 1'b0;
            mval_reg   <= 1'b0;
            close_reg  <= 1'b0;
            plain_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            dvalid_reg <= dvalid_next;
            mval_reg   <= mval_next;
            close_reg  <= close_next;
            plain_reg  <= plain_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg    <= px_next;    py_reg    <= py_next;    last_reg  <= last_next;
        fx_reg    <= fx_next;    fy_reg    <= fy_next;
        cx_reg    <= cx_next;    cy_reg    <= cy_next;
        fdx_reg   <= fdx_next;   fdy_reg   <= fdy_next;
        idx_reg   <= idx_next;   idy_reg   <= idy_next;
        dux_reg   <= dux_next;   duy_reg   <= duy_next;
        ax_reg    <= ax_next;    ay_reg    <= ay_next;
        bx_reg    <= bx_next;    by_reg    <= by_next;
        jx_reg    <= jx_next;    jy_reg    <= jy_next;
        jl_reg    <= jl_next;    jt_reg    <= jt_next;
        jr_reg    <= jr_next;    jb_reg    <= jb_next;
        pl_reg    <= pl_next;    pt_reg    <= pt_next;
        pr_reg    <= pr_next;    pb_reg    <= pb_next;
        mx_reg    <= mx_next;    my_reg    <= my_next;
        sgnx_reg  <= sgnx_next;  sgny_reg  <= sgny_next;
        mag_reg   <= mag_next;
        dot_reg   <= dot_next;   cross_reg <= cross_next;
        acc_reg   <= acc_next;
        ox_reg    <= ox_next;    oy_reg    <= oy_next;
        mdata_reg <= mdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = {{(M_TDATA_W - 4 * OUT_W){1'b0}}, mdata_reg};

    `SPBB_ASSERT_NEXT(a_busy_after_word, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SPBB_ASSERT_IMPL(a_done_only_waiting, aclk, aresetn, it_done, state_reg == ST_SQW || state_reg == ST_DXW || state_reg == ST_DYW || state_reg == ST_JXW || state_reg == ST_JYW)
    `SPBB_ASSERT_IMPL(a_dir_needs_point, aclk, aresetn, dvalid_reg, cnt_reg != 2'd0)
    `SPBB_ASSERT_NEXT(a_result_loaded, aclk, aresetn, state_reg == ST_OUT && (!m_tvalid || m_tready), m_tvalid)

endmodule

`default_nettype wire

// File: tb/stroked_polyline_bounding_box_core_checker.sv
// Checker for the stroked polyline bounding box core: predicts and compares result words
`timescale 1ns / 100ps
`default_nettype none

module stroked_polyline_bounding_box_core_checker import spbb_pkg::*; (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    input  wire                  s_tready,
    input  wire [S_TDATA_W-1:0]  s_tdata,
    input  wire                  s_tlast,
    input  wire                  m_tvalid,
    input  wire                  m_tready,
    input  wire [M_TDATA_W-1:0]  m_tdata,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [APB_ADDR_W-1:0] paddr,
    input  wire [31:0]           pwdata,
    output int                   error_count,
    output int                   boxes_pending
);

    typedef struct packed {
        logic [16:0] left;
        logic [16:0] top;
        logic [16:0] width;
        logic [16:0] height;
    } box_word_t;

    box_word_t box_queue[$];

    logic [7:0] thick_q;
    logic       miter_q;
    logic       proj_q;

    longint start_pt[2];
    longint vertex_pt[2];
    longint dir_first[2];
    longint dir_in[2];
    longint joins[4];
    longint extents[4];
    int     npts;
    bit     have_dir;

    assign boxes_pending = box_queue.size();

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic void grow_box(ref longint bx[4], input longint l, input longint t,
                                     input longint r, input longint b);
        if (l < bx[0]) bx[0] = l;
        if (t < bx[1]) bx[1] = t;
        if (r > bx[2]) bx[2] = r;
        if (b > bx[3]) bx[3] = b;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= r + bt) begin
                n -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic void unit_vector(input longint dx, input longint dy, ref longint u[2]);
        longint unsigned mx, my, m, mag, qx, qy;
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        m = mx > my ? mx : my;
        while (m >= (64'd1 << 31)) begin
            mx >>= 1; my >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 30)) begin
            mx <<= 1; my <<= 1; m <<= 1;
        end
        mag = int_sqrt(mx * mx + my * my);
        qx = ((mx << (FRAC_BITS + 1)) + mag) / (2 * mag);
        qy = ((my << (FRAC_BITS + 1)) + mag) / (2 * mag);
        u[0] = dx < 0 ? -longint'(qx) : longint'(qx);
        u[1] = dy < 0 ? -longint'(qy) : longint'(qy);
    endfunction

    // a points back to the previous vertex, b ahead to the next
    function automatic void add_join_box(input longint x, input longint y,
                                         input longint a[2], input longint b[2]);
        longint t, dot, crs, sx, sy, ox, oy;
        longint unsigned adot, den;
        t = thick_q;
        dot = a[0] * b[0] + a[1] * b[1];
        crs = a[0] * b[1] - a[1] * b[0];
        adot = dot < 0 ? -dot : dot;
        if ((adot << (48 - 2 * FRAC_BITS)) > (COS_LIMIT_Q30 << 18) || crs == 0) begin
            grow_box(joins, x - t / 2, y - t / 2, x + (t + 1) / 2, y + (t + 1) / 2);
        end else begin
            sx = a[0] + b[0];
            sy = a[1] + b[1];
            if (sx < 0) sx = -sx;
            if (sy < 0) sy = -sy;
            den = 2 * (crs < 0 ? -crs : crs);
            ox = (((t * sx) << FRAC_BITS) + den - 1) / den;
            oy = (((t * sy) << FRAC_BITS) + den - 1) / den;
            grow_box(joins, x - ox, y - oy, x + ox, y + oy);
        end
    endfunction

    function automatic logic [16:0] clamp_pos(input longint v);
        if (v < -65536) v = -65536;
        if (v > 65535) v = 65535;
        return v[16:0];
    endfunction

    function automatic logic [16:0] clamp_len(input longint v);
        if (v < 0) v = 0;
        if (v > 131071) v = 131071;
        return v[16:0];
    endfunction

    task automatic take_point(input logic [15:0] xr, input logic [15:0] yr, input logic fin);
        longint px, py, l, t, r, b, c, th;
        longint d[2];
        longint a[2];
        box_word_t w;
        px = longint'($signed(xr));
        py = longint'($signed(yr));
        if (npts == 0) begin
            start_pt = '{px, py};
            vertex_pt = '{px, py};
            have_dir = 0;
            joins = '{px, py, px, py};
            extents = '{px, py, px, py};
            npts = 1;
        end else begin
            if (npts < 3) npts++;
            grow_box(extents, px, py, px, py);
            if (px != vertex_pt[0] || py != vertex_pt[1]) begin
                unit_vector(px - vertex_pt[0], py - vertex_pt[1], d);
                if (!have_dir) begin
                    dir_first = d;
                    have_dir = 1;
                end else begin
                    a = '{-dir_in[0], -dir_in[1]};
                    add_join_box(vertex_pt[0], vertex_pt[1], a, d);
                end
                dir_in = d;
                vertex_pt = '{px, py};
            end
        end
        if (!fin) return;
        if (thick_q == 0 || !miter_q || npts <= 2) begin
            th = thick_q / 2;
            l = extents[0] - th; t = extents[1] - th;
            r = extents[2] + th; b = extents[3] + th;
        end else begin
            if (px == start_pt[0] && py == start_pt[1]) begin
                if (have_dir) begin
                    a = '{-dir_in[0], -dir_in[1]};
                    add_join_box(start_pt[0], start_pt[1], a, dir_first);
                end
            end else begin
                c = proj_q ? thick_q : thick_q / 2;
                grow_box(joins, start_pt[0] - c, start_pt[1] - c,
                         start_pt[0] + c, start_pt[1] + c);
                grow_box(joins, px - c, py - c, px + c, py + c);
            end
            l = joins[0]; t = joins[1]; r = joins[2]; b = joins[3];
        end
        w.left = clamp_pos(l);
        w.top = clamp_pos(t);
        w.width = clamp_len(r - l + 1);
        w.height = clamp_len(b - t + 1);
        box_queue = {box_queue, w};
        npts = 0;
        have_dir = 0;
    endtask

    always @(posedge aclk) begin
        box_word_t want;
        if (!aresetn) begin
            thick_q <= '0;
            miter_q <= 1'b0;
            proj_q <= 1'b0;
            npts = 0;
            have_dir = 0;
            box_queue.delete();
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_THICK: thick_q <= pwdata[7:0];
                    REG_MITER: miter_q <= pwdata[0];
                    REG_PROJ:  proj_q <= pwdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_point(s_tdata[15:0], s_tdata[31:16], s_tlast);
            if (m_tvalid && m_tready) begin
                if (box_queue.size() == 0) begin
                    report_mismatch("unexpected result words", 1, 0);
                end else begin
                    want = box_queue.pop_front();
                    if (m_tdata[16:0] !== want.left)
                        report_mismatch("box_left", $signed(m_tdata[16:0]), $signed(want.left));
                    if (m_tdata[33:17] !== want.top)
                        report_mismatch("box_top", $signed(m_tdata[33:17]), $signed(want.top));
                    if (m_tdata[50:34] !== want.width)
                        report_mismatch("box_width", m_tdata[50:34], want.width);
                    if (m_tdata[67:51] !== want.height)
                        report_mismatch("box_height", m_tdata[67:51], want.height);
                end
            end
        end
    end

    initial error_count = 0;

endmodule

`default_nettype wire

// File: tb/stroked_polyline_bounding_box_core_tb.sv
// Testbench top for the stroked polyline bounding box core: stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none

module stroked_polyline_bounding_box_core_tb;
    import spbb_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // point_x, point_y
    logic                  s_tlast = 1'b0; // last_point
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // box_left, box_top, box_width, box_height
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int  error_count;
    int  boxes_pending;
    int  cycle_count = 0;
    bit  hold_off = 1'b0;
    bit  sink_on = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    stroked_polyline_bounding_box_core i_dut (.*);

    stroked_polyline_bounding_box_core_checker i_checker (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("stroked_polyline_bounding_box_core_tb: done, errors");
            $finish;
        end
    end

    // result side: random stall per word, plus one long hold-off
    initial begin
        int gap;
        wait (sink_on);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (2000) @(posedge aclk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic fin,
                              input bit gaps);
        int gap;
        gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18)) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        s_tlast <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_and_idle();
        s_tvalid <= 1'b0;
        while (boxes_pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_coord(input int spread);
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    task automatic random_polyline(input int npts);
        logic [15:0] fx, fy, x, y;
        int spread;
        bit closed;
        spread = $urandom_range(0, 1) ? 40 : 20000;
        closed = $urandom_range(0, 2) == 0;
        fx = rand_coord(spread);
        fy = rand_coord(spread);
        x = fx; y = fy;
        for (int k = 0; k < npts; k++) begin
            if (k > 0 && $urandom_range(0, 6) != 0) begin
                x = rand_coord(spread);
                y = rand_coord(spread);
            end
            if (k == npts - 1 && closed) begin
                x = fx; y = fy;
            end
            send_point(x, y, k == npts - 1, 1'b1);
        end
    endtask

    initial begin
        int sent;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sink_on = 1'b1;

        // plain extents at reset values, single point, extremes
        send_point(16'h8000, 16'h7fff, 1'b1, 1'b0);
        send_point(16'h7fff, 16'h8000, 1'b0, 1'b0);
        send_point(16'h8000, 16'h7fff, 1'b1, 1'b0);
        drain_and_idle();
        write_reg(REG_THICK, 32'd255);
        write_reg(REG_MITER, 32'd1);
        write_reg(REG_PROJ, 32'd1);
        // open line with sharp and shallow turns
        send_point(16'd0, 16'd0, 1'b0, 1'b0);
        send_point(16'd100, 16'd0, 1'b0, 1'b0);
        send_point(16'd100, 16'd0, 1'b0, 1'b0);
        send_point(16'd200, 16'd3, 1'b0, 1'b0);
        send_point(16'd0, 16'd10, 1'b1, 1'b0);
        // closed triangle with a duplicate before closing
        send_point(16'd10, 16'd10, 1'b0, 1'b0);
        send_point(16'd50, 16'd10, 1'b0, 1'b0);
        send_point(16'd50, 16'd50, 1'b0, 1'b0);
        send_point(16'd50, 16'd50, 1'b0, 1'b0);
        send_point(16'd10, 16'd10, 1'b1, 1'b0);
        // closed line that never moves
        send_point(16'd5, 16'd5, 1'b0, 1'b0);
        send_point(16'd5, 16'd5, 1'b0, 1'b0);
        send_point(16'd5, 16'd5, 1'b1, 1'b0);
        // reversal at extreme coordinates
        send_point(16'h8000, 16'h8000, 1'b0, 1'b0);
        send_point(16'h7fff, 16'h7fff, 1'b0, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0, 1'b0);
        send_point(16'h7fff, 16'h8000, 1'b1, 1'b0);
        drain_and_idle();

        sent = 0;
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(REG_THICK, phase == 1 ? 32'd0 : (phase == 2 ? 32'd255 : $urandom_range(1, 255)));
            write_reg(REG_MITER, phase == 3 ? 32'd0 : 32'($urandom_range(0, 7) != 0));
            write_reg(REG_PROJ, 32'($urandom_range(0, 1)));
            if (phase == 4) hold_off = 1'b1;
            while (sent < (phase + 1) * 137) begin
                int n;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
                random_polyline(n);
                sent += n;
            end
            drain_and_idle();
        end

        if (error_count == 0)
            $display("stroked_polyline_bounding_box_core_tb: done, clean");
        else
            $display("stroked_polyline_bounding_box_core_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// File: stroked_polyline_bounding_box_core.f
+incdir+rtl
rtl/spbb_pkg.sv
rtl/spbb_iter.sv
rtl/stroked_polyline_bounding_box_core.sv
tb/stroked_polyline_bounding_box_core_checker.sv
tb/stroked_polyline_bounding_box_core_tb.sv
